[rtl/tcce_pkg.sv]
// Shared types, codes and defaults for the text console cursor engine.
package tcce_pkg;

  // Default geometry
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // Fixed field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned IDX_W    = 11;
  localparam int unsigned CELL_W   = 16;
  localparam int unsigned OROW_W   = 5;
  localparam int unsigned OCOL_W   = 7;
  localparam int unsigned OPOS_W   = 11;
  localparam int unsigned COLOR_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG = 1'd1;

  // Configuration reset values
  localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'h20;

  // Cell value after reset: white blank on black
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUT   = 2'd0,
    FUNC_BS    = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_BLANK,
    ST_SCROLL,
    ST_CLEAR,
    ST_EMIT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take;
    logic exec_put;
    logic exec_bs;
    logic home;
    logic rd_issue;
    logic bs_write;
    logic walk_clr;
    logic walk_inc;
    logic walk_fill;
    logic init_fill;
    logic scroll_step;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    func_e func;
    logic  put_scroll;
    logic  walk_last_clear;
    logic  walk_last_scroll;
  } sts_t;

endpackage

[rtl/tcce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tcce_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tcce_ctrl.sv]
// Controller state machine: sequences operations, store walks and result handoff.
module tcce_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  tcce_pkg::sts_t sts_i,
  output tcce_pkg::cmd_t cmd_o
);

  import tcce_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        // fill the store with the reset blank
        cmd_o.walk_fill = 1'b1;
        cmd_o.init_fill = 1'b1;
        cmd_o.walk_inc  = 1'b1;
        if (sts_i.walk_last_clear) begin
          cmd_o.walk_inc = 1'b0;
          cmd_o.walk_clr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.func)
          FUNC_PUT: begin
            cmd_o.exec_put = 1'b1;
            state_d        = sts_i.put_scroll ? ST_SCROLL : ST_EMIT;
          end
          FUNC_BS: begin
            cmd_o.exec_bs = 1'b1;
            state_d       = ST_BLANK;
          end
          FUNC_CLEAR: begin
            cmd_o.home = 1'b1;
            state_d    = ST_CLEAR;
          end
          FUNC_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_EMIT;
          end
          default: state_d = ST_EMIT;
        endcase
      end
      ST_BLANK: begin
        cmd_o.bs_write = 1'b1;
        state_d        = ST_EMIT;
      end
      ST_SCROLL: begin
        // move each row up one, then blank the last row
        cmd_o.scroll_step = 1'b1;
        cmd_o.walk_inc    = 1'b1;
        if (sts_i.walk_last_scroll) begin
          cmd_o.walk_inc = 1'b0;
          cmd_o.walk_clr = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_CLEAR: begin
        cmd_o.walk_fill = 1'b1;
        cmd_o.walk_inc  = 1'b1;
        if (sts_i.walk_last_clear) begin
          cmd_o.walk_inc = 1'b0;
          cmd_o.walk_clr = 1'b1;
          state_d        = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // load the output word once the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Track the pending output word
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[rtl/tcce_datapath.sv]
// Datapath: cursor, colors, cell store addressing, walk counter and output registers.
module tcce_datapath #(
  parameter int unsigned COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [tcce_pkg::COLOR_W-1:0]     cfg_data_i,
  input  logic [tcce_pkg::FUNC_W-1:0]      func_i,
  input  logic [tcce_pkg::CHAR_W-1:0]      char_code_i,
  input  logic [tcce_pkg::IDX_W-1:0]       cell_index_i,
  input  tcce_pkg::cmd_t                   cmd_i,
  output tcce_pkg::sts_t                   sts_o,
  output logic [tcce_pkg::CELL_W-1:0]      read_cell_o,
  output logic [tcce_pkg::OROW_W-1:0]      cursor_row_o,
  output logic [tcce_pkg::OCOL_W-1:0]      cursor_col_o,
  output logic [tcce_pkg::OPOS_W-1:0]      cursor_pos_o
);

  import tcce_pkg::*;

  localparam int unsigned CellCount = ROWS * COLUMNS;
  localparam int unsigned MoveCount = (ROWS - 1) * COLUMNS;
  localparam int unsigned AddrW     = $clog2(CellCount);
  localparam int unsigned CntW      = $clog2(CellCount + 1);
  localparam int unsigned ColW      = $clog2(COLUMNS + 4);
  localparam int unsigned RowW      = $clog2(ROWS + 1);
  localparam int unsigned LinW      = (AddrW > IDX_W) ? AddrW : IDX_W;
  localparam int unsigned CmpW      = LinW + 1;

  // Item, cursor, color and walk registers
  func_e              func_q;
  logic [CHAR_W-1:0]  char_q;
  logic [IDX_W-1:0]   idx_q;
  logic [RowW-1:0]    row_q, row_d;
  logic [ColW-1:0]    col_q, col_d;
  logic [COLOR_W-1:0] fg_q, bg_q;
  logic [CntW-1:0]    cnt_q, cnt_d;

  // Output registers
  logic [CELL_W-1:0]  out_cell_q;
  logic [OROW_W-1:0]  out_row_q;
  logic [OCOL_W-1:0]  out_col_q;
  logic [OPOS_W-1:0]  out_pos_q;

  // Combinational helpers
  logic [CHAR_W-1:0]  attr;
  logic [CELL_W-1:0]  blank;
  logic [LinW-1:0]    cursor_lin;
  logic [AddrW-1:0]   cursor_addr;
  logic [CmpW-1:0]    idx_ext;
  logic               in_range;
  logic [ColW-1:0]    tab_sum;
  logic [ColW-1:0]    put_col, bs_col;
  logic [RowW-1:0]    put_row, bs_row;
  logic               put_scroll;
  logic               printable;
  logic [CntW-1:0]    cnt_m1;
  logic [CntW-1:0]    scroll_src;

  // RAM port signals
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  assign attr        = {bg_q, fg_q};
  assign blank       = {attr, CH_BLANK};
  assign cursor_lin  = LinW'(row_q * COLUMNS) + LinW'(col_q);
  assign cursor_addr = cursor_lin[AddrW-1:0];
  assign idx_ext     = CmpW'(idx_q);
  assign in_range    = (idx_ext < CmpW'(CellCount));
  assign tab_sum     = col_q + ColW'(4);
  assign cnt_m1      = cnt_q - 1'b1;
  assign scroll_src  = cnt_q + CntW'(COLUMNS);

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q <= func_e'(func_i);
      char_q <= char_code_i;
      idx_q  <= cell_index_i;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FG:  fg_q <= cfg_data_i;
        CFG_BG:  bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Put-char cursor advance with wrap and bottom clamp
  always_comb begin
    put_col   = col_q;
    put_row   = row_q;
    printable = 1'b0;
    case (char_q)
      CH_NEWLINE: begin
        put_col = '0;
        put_row = row_q + 1'b1;
      end
      CH_RETURN: put_col = '0;
      CH_TAB:    put_col = {tab_sum[ColW-1:2], 2'b00};
      default: begin
        printable = 1'b1;
        put_col   = col_q + 1'b1;
      end
    endcase
    if (put_col >= ColW'(COLUMNS)) begin
      put_col = '0;
      put_row = put_row + 1'b1;
    end
    put_scroll = (put_row >= RowW'(ROWS));
    if (put_scroll) begin
      put_row = RowW'(ROWS - 1);
    end
  end

  // Backspace cursor step
  always_comb begin
    bs_col = col_q;
    bs_row = row_q;
    if (col_q != '0) begin
      bs_col = col_q - 1'b1;
    end else if (row_q != '0) begin
      bs_row = row_q - 1'b1;
      bs_col = ColW'(COLUMNS - 1);
    end
  end

  // Cursor update
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.exec_put) begin
      row_d = put_row;
      col_d = put_col;
    end else if (cmd_i.exec_bs) begin
      row_d = bs_row;
      col_d = bs_col;
    end
  end

  // Walk counter
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.walk_clr) begin
      cnt_d = '0;
    end else if (cmd_i.walk_inc) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      cnt_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      cnt_q <= cnt_d;
    end
  end

  // Store port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cursor_addr;
    ram_wdata = blank;
    ram_re    = 1'b0;
    ram_raddr = idx_ext[AddrW-1:0];
    if (cmd_i.exec_put && printable) begin
      ram_we    = 1'b1;
      ram_wdata = {attr, char_q};
    end
    if (cmd_i.bs_write) begin
      ram_we = 1'b1;
    end
    if (cmd_i.walk_fill) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_q[AddrW-1:0];
      ram_wdata = cmd_i.init_fill ? RESET_CELL : blank;
    end
    if (cmd_i.scroll_step) begin
      // write one cell behind the read; the tail row gets blanks
      ram_we    = (cnt_q != '0);
      ram_waddr = cnt_m1[AddrW-1:0];
      ram_wdata = (cnt_m1 < CntW'(MoveCount)) ? ram_rdata : blank;
      ram_re    = (cnt_q < CntW'(MoveCount));
      ram_raddr = scroll_src[AddrW-1:0];
    end
    if (cmd_i.rd_issue) begin
      ram_re = in_range;
    end
  end

  tcce_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CellCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Load the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_cell_q <= (func_q == FUNC_READ && in_range) ? ram_rdata : '0;
      out_row_q  <= OROW_W'(row_q);
      out_col_q  <= OCOL_W'(col_q);
      out_pos_q  <= cursor_lin[OPOS_W-1:0];
    end
  end

  // Status
  assign sts_o.func             = func_q;
  assign sts_o.put_scroll       = put_scroll;
  assign sts_o.walk_last_clear  = (cnt_q == CntW'(CellCount - 1));
  assign sts_o.walk_last_scroll = (cnt_q == CntW'(CellCount));

  assign read_cell_o  = out_cell_q;
  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cursor_pos_o = out_pos_q;

endmodule

[rtl/text_console_cursor_engine_top.sv]
// Top level of the text console engine: controller, datapath and cell store.
// Scroll moves one cell per cycle through the store's separate read and write ports.
// Clear writes the blank to every cell; one word is in flight at a time.
// Reset: after rst_ni releases, a fill pass writes the white-on-black blank to all
// ROWS*COLUMNS cells with in_stall_o high.
module text_console_cursor_engine_top #(
  parameter int unsigned COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcce_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [tcce_pkg::COLOR_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [tcce_pkg::FUNC_W-1:0]    func_i,
  input  logic [tcce_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcce_pkg::IDX_W-1:0]     cell_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [tcce_pkg::CELL_W-1:0]    read_cell_o,
  output logic [tcce_pkg::OROW_W-1:0]    cursor_row_o,
  output logic [tcce_pkg::OCOL_W-1:0]    cursor_col_o,
  output logic [tcce_pkg::OPOS_W-1:0]    cursor_pos_o
);

  import tcce_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcce_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tcce_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_cell_o  (read_cell_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .cursor_pos_o (cursor_pos_o)
  );

endmodule

[rtl/tcce_checker.sv]
// Port-level checker for the text console engine, bound to the top level.
module tcce_checker #(
  parameter int unsigned COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcce_pkg::ROWS_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [tcce_pkg::CELL_W-1:0]    read_cell_o,
  input logic [tcce_pkg::OROW_W-1:0]    cursor_row_o,
  input logic [tcce_pkg::OCOL_W-1:0]    cursor_col_o,
  input logic [tcce_pkg::OPOS_W-1:0]    cursor_pos_o
);

  import tcce_pkg::*;

  localparam bit Exact = (ROWS <= 32) && (COLUMNS <= 128);

  // Block is busy with the store fill right after reset
  a_init_busy: assert property (@(posedge clk_i) $rose(rst_ni) |-> in_stall_o)
    else $error("input not stalled during the reset fill");

  // One word at a time: stall rises after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("accepted a word while busy");

  // A stalled output word is not dropped, and its cell and position do not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(read_cell_o) &&
      $stable(cursor_pos_o)))
    else $error("stalled output word changed");

  // Cursor stays on the screen and its linear position matches row and column
  a_cursor_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && Exact) |-> ((32'(cursor_row_o) < ROWS) &&
      (32'(cursor_col_o) < COLUMNS) &&
      (cursor_pos_o == OPOS_W'(32'(cursor_row_o) * COLUMNS + 32'(cursor_col_o)))))
    else $error("cursor position inconsistent");

endmodule

bind text_console_cursor_engine_top tcce_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcce_checker (.*);

[tb/sv/testbench.sv]
// Self-checking testbench for the text console engine: directed table, then random phases.
module testbench;
  import tcce_pkg::*;

  localparam int unsigned COLS  = COLUMNS_DEF;
  localparam int unsigned LINES = ROWS_DEF;
  localparam int unsigned CELLS = COLS * LINES;
  localparam int unsigned DIR_N = 20;
  localparam int unsigned PHASES = 4;
  localparam int unsigned PHASE_ITEMS = 100;

  // One result word: cell read and cursor after the operation
  typedef struct packed {
    logic [CELL_W-1:0] rd_word;
    logic [OROW_W-1:0] row;
    logic [OCOL_W-1:0] col;
    logic [OPOS_W-1:0] pos;
  } console_view_t;

  // One row of the directed table
  typedef struct packed {
    func_e             f;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic              typed;
    console_view_t     want;
  } stim_row_t;

  // Kinds of random runs
  typedef enum logic [1:0] {
    RUN_GLYPH,
    RUN_NEWLINE,
    RUN_ERASE,
    RUN_TAB
  } run_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [COLOR_W-1:0]   cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [FUNC_W-1:0]    func_i = '0;
  logic [CHAR_W-1:0]    char_code_i = '0;
  logic [IDX_W-1:0]     cell_index_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CELL_W-1:0]    read_cell_o;
  logic [OROW_W-1:0]    cursor_row_o;
  logic [OCOL_W-1:0]    cursor_col_o;
  logic [OPOS_W-1:0]    cursor_pos_o;

  // Console shadow state
  logic [CELL_W-1:0]  screen_mdl [CELLS];
  int unsigned        row_mdl;
  int unsigned        col_mdl;
  logic [COLOR_W-1:0] fg_mdl;
  logic [COLOR_W-1:0] bg_mdl;

  console_view_t pending_views [$];
  stim_row_t     dir_tab [DIR_N];
  int unsigned   fail_cnt = 0;
  bit            send_calm = 1'b0;
  bit            recv_calm = 1'b0;
  int unsigned   stall_left = 0;
  run_e          run_kind = RUN_GLYPH;
  int unsigned   run_left = 0;
  console_view_t got_v;
  console_view_t want_v;

  text_console_cursor_engine_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_cell_o  (read_cell_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .cursor_pos_o (cursor_pos_o)
  );

  always #10 clk_i = ~clk_i;

  // Blank cell in the current colours
  function automatic logic [CELL_W-1:0] blank_word();
    return {bg_mdl, fg_mdl, CH_BLANK};
  endfunction

  // Idle length: mostly short, a few long, none while calm
  function automatic int unsigned idle_len(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Apply one operation to the shadow console and return the resulting view
  task automatic advance_console(input func_e f, input logic [CHAR_W-1:0] ch,
                                 input logic [IDX_W-1:0] idx, output console_view_t v);
    int unsigned k;
    int unsigned pos;
    logic [CELL_W-1:0] rd_word;
    rd_word = '0;
    case (f)
      FUNC_PUT: begin
        if (ch == CH_NEWLINE) begin
          col_mdl = 0;
          row_mdl++;
        end else if (ch == CH_RETURN) begin
          col_mdl = 0;
        end else if (ch == CH_TAB) begin
          col_mdl = (col_mdl + 4) & ~32'd3;
        end else begin
          screen_mdl[row_mdl * COLS + col_mdl] = {bg_mdl, fg_mdl, ch};
          col_mdl++;
        end
        // wrap at the line end
        if (col_mdl >= COLS) begin
          col_mdl = 0;
          row_mdl++;
        end
        // scroll up one row past the bottom
        if (row_mdl >= LINES) begin
          for (k = 0; k < (LINES - 1) * COLS; k++) screen_mdl[k] = screen_mdl[k + COLS];
          for (k = (LINES - 1) * COLS; k < CELLS; k++) screen_mdl[k] = blank_word();
          row_mdl = LINES - 1;
        end
      end
      FUNC_BS: begin
        if (col_mdl > 0) begin
          col_mdl--;
        end else if (row_mdl > 0) begin
          row_mdl--;
          col_mdl = COLS - 1;
        end
        screen_mdl[row_mdl * COLS + col_mdl] = blank_word();
      end
      FUNC_CLEAR: begin
        for (k = 0; k < CELLS; k++) screen_mdl[k] = blank_word();
        row_mdl = 0;
        col_mdl = 0;
      end
      default: begin
        if (idx < CELLS) rd_word = screen_mdl[idx];
      end
    endcase
    pos = row_mdl * COLS + col_mdl;
    v.rd_word = rd_word;
    v.row     = row_mdl[OROW_W-1:0];
    v.col     = col_mdl[OCOL_W-1:0];
    v.pos     = pos[OPOS_W-1:0];
  endtask

  // Offer one word after a random gap, hold it until taken, then log its expectation
  task automatic offer_word(input func_e f, input logic [CHAR_W-1:0] ch,
                            input logic [IDX_W-1:0] idx, input logic typed,
                            input console_view_t want);
    int unsigned gap;
    console_view_t pred;
    if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
    gap = idle_len(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    advance_console(f, ch, idx, pred);
    pending_views.push_back(typed ? want : pred);
  endtask

  // Write one colour register while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_FG) fg_mdl = val;
    else bg_mdl = val;
  endtask

  // Check each output word against the oldest expectation, then shape the stall
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_v = {read_cell_o, cursor_row_o, cursor_col_o, cursor_pos_o};
      if (pending_views.size() == 0) begin
        if (fail_cnt < 10)
          $display("unexpected word: cell %h row %0d col %0d pos %0d",
                   got_v.rd_word, got_v.row, got_v.col, got_v.pos);
        fail_cnt++;
      end else begin
        want_v = pending_views.pop_front();
        if (got_v != want_v) begin
          if (fail_cnt < 10)
            $display({"mismatch: exp cell %h row %0d col %0d pos %0d, ",
                      "got cell %h row %0d col %0d pos %0d"},
                     want_v.rd_word, want_v.row, want_v.col, want_v.pos,
                     got_v.rd_word, got_v.row, got_v.col, got_v.pos);
          fail_cnt++;
        end
      end
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
      if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      stall_left = idle_len(recv_calm);
    end
  end

  // Run bound
  initial begin
    #80000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned   i;
    int unsigned   p;
    int unsigned   r;
    int unsigned   pos;
    func_e         f;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    logic [COLOR_W-1:0] fg_new;
    logic [COLOR_W-1:0] bg_new;

    for (i = 0; i < CELLS; i++) screen_mdl[i] = RESET_CELL;
    row_mdl = 0;
    col_mdl = 0;
    fg_mdl  = FG_RESET;
    bg_mdl  = BG_RESET;

    // after reset, extremes of index and char, control codes, backspace at home and across rows
    dir_tab[0]  = '{FUNC_READ,  8'h00,      11'd0,    1'b1, '{16'h0F20, 5'd0, 7'd0,  11'd0}};
    dir_tab[1]  = '{FUNC_READ,  8'hFF,      11'd1999, 1'b1, '{16'h0F20, 5'd0, 7'd0,  11'd0}};
    dir_tab[2]  = '{FUNC_READ,  8'h00,      11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd0,  11'd0}};
    dir_tab[3]  = '{FUNC_BS,    8'h00,      11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0,  11'd0}};
    dir_tab[4]  = '{FUNC_READ,  8'h00,      11'd0,    1'b1, '{16'h0F20, 5'd0, 7'd0,  11'd0}};
    dir_tab[5]  = '{FUNC_PUT,   8'h41,      11'd2047, 1'b1, '{16'h0000, 5'd0, 7'd1,  11'd1}};
    dir_tab[6]  = '{FUNC_PUT,   8'hFF,      11'd0,    1'b1, '{16'h0000, 5'd0, 7'd2,  11'd2}};
    dir_tab[7]  = '{FUNC_PUT,   8'h00,      11'd0,    1'b1, '{16'h0000, 5'd0, 7'd3,  11'd3}};
    dir_tab[8]  = '{FUNC_READ,  8'h00,      11'd1,    1'b1, '{16'h0FFF, 5'd0, 7'd3,  11'd3}};
    dir_tab[9]  = '{FUNC_PUT,   CH_TAB,     11'd0,    1'b0, '0};
    dir_tab[10] = '{FUNC_PUT,   CH_TAB,     11'd0,    1'b0, '0};
    dir_tab[11] = '{FUNC_PUT,   CH_RETURN,  11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0,  11'd0}};
    dir_tab[12] = '{FUNC_PUT,   CH_NEWLINE, 11'd0,    1'b0, '0};
    dir_tab[13] = '{FUNC_BS,    8'h00,      11'd0,    1'b0, '0};
    dir_tab[14] = '{FUNC_READ,  8'h00,      11'd79,   1'b0, '0};
    dir_tab[15] = '{FUNC_PUT,   8'h7E,      11'd0,    1'b0, '0};
    dir_tab[16] = '{FUNC_READ,  8'h00,      11'd79,   1'b0, '0};
    dir_tab[17] = '{FUNC_READ,  8'h00,      11'd2000, 1'b1, '{16'h0000, 5'd1, 7'd0,  11'd80}};
    dir_tab[18] = '{FUNC_CLEAR, 8'h00,      11'd0,    1'b1, '{16'h0000, 5'd0, 7'd0,  11'd0}};
    dir_tab[19] = '{FUNC_READ,  8'h00,      11'd2,    1'b0, '0};

    // hold reset, then release
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    for (i = 0; i < DIR_N; i++)
      offer_word(dir_tab[i].f, dir_tab[i].ch, dir_tab[i].idx, dir_tab[i].typed,
                 dir_tab[i].want);

    // random phases, colours changed only once the block has drained
    for (p = 0; p < PHASES; p++) begin
      in_valid_i <= 1'b0;
      while (pending_views.size() != 0) @(posedge clk_i);
      case (p)
        0: begin fg_new = '0; bg_new = '0; end
        1: begin fg_new = '1; bg_new = '1; end
        default: begin
          fg_new = COLOR_W'($urandom_range(0, 15));
          bg_new = COLOR_W'($urandom_range(0, 15));
        end
      endcase
      write_reg(CFG_FG, fg_new);
      write_reg(CFG_BG, bg_new);
      cfg_we_i <= 1'b0;

      for (i = 0; i < PHASE_ITEMS; i++) begin
        ch  = CHAR_W'($urandom_range(0, 255));
        idx = IDX_W'($urandom_range(0, 2047));
        f   = FUNC_PUT;
        // start a run now and then: glyphs to the line end, newlines to the bottom, erases, tabs
        if (run_left == 0 && $urandom_range(0, 24) == 0) begin
          run_kind = run_e'($urandom_range(0, 3));
          case (run_kind)
            RUN_GLYPH:   run_left = $urandom_range(20, 90);
            RUN_NEWLINE: run_left = $urandom_range(3, 26);
            RUN_ERASE:   run_left = $urandom_range(5, 90);
            default:     run_left = $urandom_range(5, 25);
          endcase
        end
        if (run_left > 0) begin
          run_left--;
          case (run_kind)
            RUN_GLYPH:   f = FUNC_PUT;
            RUN_NEWLINE: ch = CH_NEWLINE;
            RUN_ERASE:   f = FUNC_BS;
            default:     ch = CH_TAB;
          endcase
        end else begin
          r = $urandom_range(0, 99);
          if (r < 55)      f = FUNC_PUT;
          else if (r < 63) ch = CH_NEWLINE;
          else if (r < 67) ch = CH_RETURN;
          else if (r < 74) ch = CH_TAB;
          else if (r < 83) f = FUNC_BS;
          else if (r < 85) f = FUNC_CLEAR;
          else begin
            f = FUNC_READ;
            r = $urandom_range(0, 9);
            pos = row_mdl * COLS + col_mdl;
            // read anywhere, near the cursor, or beyond the store
            if (r < 6)      idx = IDX_W'($urandom_range(0, CELLS - 1));
            else if (r < 8) idx = IDX_W'((pos >= 5 ? pos - 5 : 0) + $urandom_range(0, 10));
            else            idx = IDX_W'($urandom_range(CELLS, 2047));
          end
        end
        offer_word(f, ch, idx, 1'b0, '0);
      end
    end

    // drain and let the tail settle
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
